// ===== hw/rtl/pfx_pkg.sv =====
// ============================================================================
// pfx_pkg - shared constants for the prefix expression evaluator
// Holds data widths, character codes, status codes and the default stack
// depth used by the evaluator and its divider.
// ============================================================================
package pfx_pkg;

    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STATUS_W        = 2;
    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;  // '0'
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;  // '9'
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;  // '+'
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;  // '-'
    localparam logic [SYM_W-1:0] SYM_TIMES = 8'h2A;  // '*'
    localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;  // '/'

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SYMBOL = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

endpackage

// ===== hw/rtl/pfx_divider.sv =====
// ============================================================================
// pfx_divider - iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, followed by
// a sign fix step. Truncates toward zero and wraps on overflow.
// ============================================================================
module pfx_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pfx_pkg::DATA_W-1:0] dividend,
    input  logic [pfx_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [pfx_pkg::DATA_W-1:0] quotient
);
    import pfx_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

    logic              busy_reg, fix_reg, done_reg, neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] rem_reg, quo_reg, den_reg, quotient_reg;

    logic [DATA_W:0]   shifted, diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            // The done pulse follows the sign fix cycle.
            done_reg <= fix_reg && !busy_reg && !start;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end else if (fix_reg) begin
                fix_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_reg <= divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], ge};
        end else if (fix_reg) begin
            quotient_reg <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

// ===== hw/rtl/prefix_expression_evaluator.sv =====
// A digit or an unrecognized character goes through S_IDLE and S_FINISH; '+', '-' and '*' go
// through S_POPA, S_POPB, S_EXEC, S_CALC, S_PUSH and S_FINISH. '/' adds S_DIV, where it waits
// on the bit-serial divider (32 steps + sign fix); on a zero divisor S_CALC goes straight to
// S_FINISH. The final character of an expression adds S_FPOP for the result pop and S_EMIT
// for the output load; an error skips the pop. The result beat waits in the output register.
// Reset (aresetn low, synchronous) empties the stack and clears the status.
// ============================================================================
// prefix_expression_evaluator - stack machine for prefix expressions
// Characters arrive last first; operands live in a one-port-read stack RAM
// with a registered read, sequenced by a one-hot state machine.
// ============================================================================
module prefix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input beats: one expression character each.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [pfx_pkg::SYM_W-1:0] s_tdata,   // [7:0] symbol
    input  logic                      s_tlast,   // final_symbol
    // Result beats: one per expression.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pfx_pkg::DATA_W-1:0] m_tdata,  // [31:0] value
    output logic [3:0]                m_tuser    // [1:0] status, [2] underflow_seen,
                                                 // [3] overflow_seen
);
    import pfx_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_POPA   = 10'b00_0000_0010,
        S_POPB   = 10'b00_0000_0100,
        S_EXEC   = 10'b00_0000_1000,
        S_CALC   = 10'b00_0001_0000,
        S_DIV    = 10'b00_0010_0000,
        S_PUSH   = 10'b00_0100_0000,
        S_FINISH = 10'b00_1000_0000,
        S_FPOP   = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    // Operand stack. Entries are only ever read below the fill count, so the
    // array needs no clearing.
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [DATA_W-1:0] wr_data;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [STATUS_W-1:0]  err_reg, err_next;
    logic                 uf_reg, uf_next;
    logic                 of_reg, of_next;
    logic                 final_reg, final_next;
    logic                 hit_reg, hit_next;
    op_t                  op_reg, op_next;
    logic [DATA_W-1:0]    a_reg, a_next;
    logic [DATA_W-1:0]    b_reg, b_next;
    logic [DATA_W-1:0]    res_reg, res_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]    m_data_reg, m_data_next;
    logic [3:0]           m_user_reg, m_user_next;

    logic                 div_start, div_done;
    logic [DATA_W-1:0]    div_quot;
    logic [DATA_W-1:0]    popped;
    logic                 accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    // Data of the previous pop; an empty-stack pop reads as zero.
    assign popped   = hit_reg ? rd_data_reg : '0;

    pfx_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        uf_next       = uf_reg;
        of_next       = of_reg;
        final_next    = final_reg;
        hit_next      = hit_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        rd_en         = 1'b0;
        rd_addr       = count_reg[ADDR_W-1:0] - 1'b1;
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = res_reg;
        div_start     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    final_next = s_tlast;
                    state_next = S_FINISH;
                    if (err_reg == STATUS_OK) begin
                        if (s_tdata >= SYM_ZERO && s_tdata <= SYM_NINE) begin
                            wr_data = DATA_W'(s_tdata - SYM_ZERO);
                            if (count_reg < CNT_FULL) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                of_next = 1'b1;
                            end
                        end else if (s_tdata == SYM_PLUS) begin
                            op_next    = OP_ADD;
                            state_next = S_POPA;
                        end else if (s_tdata == SYM_MINUS) begin
                            op_next    = OP_SUB;
                            state_next = S_POPA;
                        end else if (s_tdata == SYM_TIMES) begin
                            op_next    = OP_MUL;
                            state_next = S_POPA;
                        end else if (s_tdata == SYM_SLASH) begin
                            op_next    = OP_DIV;
                            state_next = S_POPA;
                        end else begin
                            err_next = STATUS_BAD_SYMBOL;
                        end
                    end
                end
            end
            S_POPA, S_POPB, S_FPOP: begin
                if (state_reg == S_POPB) begin
                    a_next = popped;
                end
                if (state_reg == S_FPOP) begin
                    res_next = popped;
                end
                if (state_reg == S_FPOP) begin
                    state_next = S_EMIT;
                end else begin
                    if (count_reg != '0) begin
                        rd_en      = 1'b1;
                        count_next = count_reg - 1'b1;
                        hit_next   = 1'b1;
                    end else begin
                        uf_next  = 1'b1;
                        hit_next = 1'b0;
                    end
                    state_next = (state_reg == S_POPA) ? S_POPB : S_EXEC;
                end
            end
            S_EXEC: begin
                b_next     = popped;
                state_next = S_CALC;
            end
            S_CALC: begin
                state_next = S_PUSH;
                unique case (op_reg)
                    OP_ADD: res_next = a_reg + b_reg;
                    OP_SUB: res_next = a_reg - b_reg;
                    OP_MUL: res_next = a_reg * b_reg;
                    OP_DIV: begin
                        if (b_reg == '0) begin
                            err_next   = STATUS_DIV_ZERO;
                            state_next = S_FINISH;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: res_next = a_reg;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = div_quot;
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (count_reg < CNT_FULL) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end else begin
                    of_next = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!final_reg) begin
                    state_next = S_IDLE;
                end else if (err_reg != STATUS_OK) begin
                    // After an error the value is zero and no final pop is made.
                    res_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    if (count_reg != '0) begin
                        rd_en      = 1'b1;
                        count_next = count_reg - 1'b1;
                        hit_next   = 1'b1;
                    end else begin
                        uf_next  = 1'b1;
                        hit_next = 1'b0;
                    end
                    state_next = S_FPOP;
                end
            end
            S_EMIT: begin
                // Load the output register once the previous beat has left.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_reg;
                    m_user_next   = {of_reg, uf_reg, err_reg};
                    count_next    = '0;
                    err_next      = STATUS_OK;
                    uf_next       = 1'b0;
                    of_next       = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            err_reg      <= STATUS_OK;
            uf_reg       <= 1'b0;
            of_reg       <= 1'b0;
            hit_reg      <= 1'b0;
            final_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            uf_reg       <= uf_next;
            of_reg       <= of_next;
            hit_reg      <= hit_next;
            final_reg    <= final_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // Stack RAM: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
